/* src/assert_macros.svh */
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on aclk, off while aresetn is low
`define HPNC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Concurrent assertion on aclk, checked through reset as well
`define HPNC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* src/hpnc_pkg.sv */
// Types, codes and constant tables of the heading PD navigation controller
`timescale 1ns / 1ps
`default_nettype none

package hpnc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_ERR,
        ST_MUL,
        ST_SQRT,
        ST_FIN,
        ST_ACT,
        ST_ECHO
    } state_t;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_MANUAL = 2'd1,
        ACT_AUTO   = 2'd2,
        ACT_REARM  = 2'd3
    } action_t;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_P_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_D_GAIN = 3'd4;

    localparam logic KIND_ACTUATOR = 1'b0;
    localparam logic KIND_ECHO     = 1'b1;

    localparam logic [6:0] ACCEL_MAX = 7'd100;

    localparam logic [15:0] SPEED_GAIN_RST   = 16'd512;
    localparam logic [15:0] ANGLE_P_GAIN_RST = 16'd768;
    localparam logic [15:0] ANGLE_D_GAIN_RST = 16'd51;

    localparam int ATAN_W = 22;

    // arctan(2^-i) in Q16 degrees
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/heading_pd_navigation_controller.sv */
// Heading PD navigation controller: speed from distance, steering from heading error
// Flow: a fault result appears the cycle after its transfer; a sample in auto mode with no fault
// runs the CORDIC, error, bit-serial multiply, square-root digit loop and final rounding steps,
// then sends its actuator result and then its echo, each when the output is free.
// No new sample is taken until its echo has been sent. Reset (aresetn low, synchronous): manual,
// fault clear.
`timescale 1ns / 1ps
`default_nettype none

module heading_pd_navigation_controller #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_action,
    input  wire logic                           s_fault_active,
    input  wire logic signed [15:0]             s_pos_x,
    input  wire logic signed [15:0]             s_pos_y,
    input  wire logic signed [9:0]              s_heading,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_result_kind,
    output logic [6:0]                          m_accel_cmd,
    output logic signed [8:0]                   m_steer_cmd,
    output logic signed [15:0]                  m_echo_x,
    output logic signed [15:0]                  m_echo_y,
    output logic signed [9:0]                   m_echo_heading,
    output logic                                m_last_item,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [hpnc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                    cfg_data
);
    import hpnc_pkg::*;

    localparam int F        = ANGLE_FRAC_BITS;
    localparam int XW       = 20;
    localparam int ZW       = 26;
    localparam int PW       = 12 + F;
    localparam int EW       = 9 + F;
    localparam int DW       = 10 + F;
    localparam int CW       = 28 + F;
    localparam int ZSH      = 16 - F;
    localparam int RS       = 8 + F;
    localparam int A_LEN    = (CORDIC_STEPS > 16) ? CORDIC_STEPS : 16;
    localparam int MUL_LEN  = 30;
    localparam int SQRT_LEN = 15;

    localparam logic [4:0] A_LAST    = 5'(A_LEN - 1);
    localparam logic [4:0] MUL_LAST  = 5'(MUL_LEN - 1);
    localparam logic [4:0] SQRT_LAST = 5'(SQRT_LEN - 1);
    localparam logic [4:0] C_STEPS   = 5'(CORDIC_STEPS);

    localparam logic signed [ZW-1:0] Z_HALF_TURN = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0] Z_ROUND     = ZW'(1 << (ZSH - 1));
    localparam logic signed [PW-1:0] P_HALF      = PW'(180 << F);
    localparam logic signed [PW-1:0] P_3HALF     = PW'(540 << F);
    localparam logic signed [PW-1:0] P_FULL      = PW'(360 << F);
    localparam logic signed [PW-1:0] P_2FULL     = PW'(720 << F);
    localparam logic signed [CW-1:0] CMD_LIM     = CW'(180 << (8 + F));
    localparam logic [CW-1:0]        CMD_RND     = CW'(1 << (RS - 1));

    state_t state_reg, state_next;
    logic [4:0] cnt_reg;

    logic signed [15:0] tx_reg, ty_reg;
    logic [15:0] sg_reg, kp_reg, kd_reg;
    logic auto_reg, auto_next, fault_reg, fault_next;
    logic signed [EW-1:0] prev_err_reg;

    logic signed [15:0] px_reg, py_reg;
    logic signed [9:0]  hd_reg;

    logic signed [XW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic zero_reg;

    logic [15:0] sqx_reg, sqy_reg, gs_reg;
    logic [31:0] sqxl_reg, sqyl_reg, gl_reg, gg_reg;
    logic [32:0] d2_reg;

    logic [29:0] d2s_reg;
    logic [61:0] ggl_reg, lhs_reg;
    logic        d2big_reg;
    logic [15:0] kps_reg, kds_reg;
    logic signed [CW-1:0] errl_reg, derrl_reg, cmd_reg;

    logic [29:0] sqv_reg;
    logic [16:0] rem_reg;
    logic [14:0] root_reg;

    logic [6:0]        accel_res_reg;
    logic signed [8:0] steer_res_reg;

    logic              m_valid_reg, m_kind_reg, m_last_reg;
    logic [6:0]        m_accel_reg;
    logic signed [8:0] m_steer_reg;
    logic signed [15:0] m_ex_reg, m_ey_reg;
    logic signed [9:0] m_eh_reg;

    logic in_xfer, out_free, start;
    logic signed [16:0] ex, ey;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign in_xfer   = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign start     = (s_action == ACT_SAMPLE) && auto_reg && !fault_reg && !s_fault_active;

    assign ex = $signed({tx_reg[15], tx_reg}) - $signed({s_pos_x[15], s_pos_x});
    assign ey = $signed({ty_reg[15], ty_reg}) - $signed({s_pos_y[15], s_pos_y});

    // CORDIC step
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] atn;
    assign xs  = cx_reg >>> cnt_reg;
    assign ys  = cy_reg >>> cnt_reg;
    assign atn = $signed({4'b0, atan_q16(cnt_reg)});

    // heading error and wrap
    logic signed [ZW-1:0] zr, zsh;
    logic signed [PW-1:0] des, hd_sc, err0, errp;
    logic signed [EW-1:0] errw;
    logic signed [DW-1:0] derr;
    always_comb begin
        zr    = cz_reg + Z_ROUND;
        zsh   = zr >>> ZSH;
        des   = zero_reg ? '0 : PW'(zsh);
        hd_sc = PW'(hd_reg) <<< F;
        err0  = des - hd_sc;
        if (err0 > P_3HALF) begin
            errp = err0 - P_2FULL;
        end else if (err0 > P_HALF) begin
            errp = err0 - P_FULL;
        end else if (err0 < -P_3HALF) begin
            errp = err0 + P_2FULL;
        end else if (err0 < -P_HALF) begin
            errp = err0 + P_FULL;
        end else begin
            errp = err0;
        end
        errw = EW'(errp);
        derr = DW'(errw) - DW'(prev_err_reg);
    end

    logic [61:0] lhs_sum;
    assign lhs_sum = lhs_reg + (d2s_reg[0] ? ggl_reg : 62'd0);

    // square-root digit
    logic [18:0] rem_sh, trial;
    assign rem_sh = {rem_reg, sqv_reg[29:28]};
    assign trial  = {2'b0, root_reg, 2'b01};

    // final rounding
    logic signed [CW-1:0] cmd_sat;
    logic [CW-1:0] cmd_mag, cmd_rnd;
    logic [8:0]  steer_mag;
    logic [15:0] k16;
    logic [7:0]  k8;
    logic [6:0]  accel_val;
    always_comb begin
        if (cmd_reg > CMD_LIM) begin
            cmd_sat = CMD_LIM;
        end else if (cmd_reg < -CMD_LIM) begin
            cmd_sat = -CMD_LIM;
        end else begin
            cmd_sat = cmd_reg;
        end
        cmd_mag   = cmd_sat[CW-1] ? CW'(-cmd_sat) : CW'(cmd_sat);
        cmd_rnd   = (cmd_mag + CMD_RND) >> RS;
        steer_mag = cmd_rnd[8:0];
        k16       = ({1'b0, root_reg} + 16'd128) >> 8;
        k8        = k16[7:0];
        if ((d2big_reg && (gg_reg != 32'd0)) || (|lhs_reg[61:30])
            || (k8 > 8'(ACCEL_MAX))) begin
            accel_val = ACCEL_MAX;
        end else begin
            accel_val = k8[6:0];
        end
    end

    // mode and fault mark
    always_comb begin
        auto_next  = auto_reg;
        fault_next = fault_reg;
        if (in_xfer) begin
            if (s_fault_active) begin
                auto_next  = 1'b0;
                fault_next = 1'b1;
            end
            case (action_t'(s_action))
                ACT_MANUAL: auto_next = 1'b0;
                ACT_AUTO: begin
                    if (!fault_next) begin
                        auto_next = 1'b1;
                    end
                end
                ACT_REARM: fault_next = 1'b0;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && start) begin
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                if (cnt_reg == A_LAST) begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR: state_next = ST_MUL;
            ST_MUL: begin
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (cnt_reg == SQRT_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: state_next = ST_ACT;
            ST_ACT: begin
                if (out_free) begin
                    state_next = ST_ECHO;
                end
            end
            ST_ECHO: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            auto_reg     <= 1'b0;
            fault_reg    <= 1'b0;
            prev_err_reg <= '0;
            tx_reg       <= '0;
            ty_reg       <= '0;
            sg_reg       <= SPEED_GAIN_RST;
            kp_reg       <= ANGLE_P_GAIN_RST;
            kd_reg       <= ANGLE_D_GAIN_RST;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? 5'd0 : cnt_reg + 5'd1;
            auto_reg  <= auto_next;
            fault_reg <= fault_next;
            if (state_reg == ST_ERR) begin
                prev_err_reg <= errw;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    REG_TARGET_X:     tx_reg <= cfg_data;
                    REG_TARGET_Y:     ty_reg <= cfg_data;
                    REG_SPEED_GAIN:   sg_reg <= cfg_data;
                    REG_ANGLE_P_GAIN: kp_reg <= cfg_data;
                    REG_ANGLE_D_GAIN: kd_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_xfer && s_fault_active) begin
                m_valid_reg <= 1'b1;
            end else if ((state_reg == ST_ACT || state_reg == ST_ECHO) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                px_reg   <= s_pos_x;
                py_reg   <= s_pos_y;
                hd_reg   <= s_heading;
                zero_reg <= (ex == 17'sd0) && (ey == 17'sd0);
                if (ex < 0) begin
                    cx_reg <= XW'(-ex);
                    cy_reg <= XW'(-ey);
                    cz_reg <= (ey >= 0) ? Z_HALF_TURN : -Z_HALF_TURN;
                end else begin
                    cx_reg <= XW'(ex);
                    cy_reg <= XW'(ey);
                    cz_reg <= '0;
                end
                sqx_reg  <= ex[16] ? 16'(-ex) : ex[15:0];
                sqy_reg  <= ey[16] ? 16'(-ey) : ey[15:0];
                sqxl_reg <= ex[16] ? 32'(16'(-ex)) : 32'(ex[15:0]);
                sqyl_reg <= ey[16] ? 32'(16'(-ey)) : 32'(ey[15:0]);
                d2_reg   <= '0;
                gs_reg   <= sg_reg;
                gl_reg   <= 32'(sg_reg);
                gg_reg   <= '0;
            end
            ST_CORDIC: begin
                if (cnt_reg < C_STEPS) begin
                    if (cy_reg > 0) begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + atn;
                    end else begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - atn;
                    end
                end
                if (!cnt_reg[4]) begin
                    d2_reg   <= d2_reg + (sqx_reg[0] ? 33'(sqxl_reg) : 33'd0)
                                       + (sqy_reg[0] ? 33'(sqyl_reg) : 33'd0);
                    sqx_reg  <= sqx_reg >> 1;
                    sqy_reg  <= sqy_reg >> 1;
                    sqxl_reg <= sqxl_reg << 1;
                    sqyl_reg <= sqyl_reg << 1;
                    gg_reg   <= gg_reg + (gs_reg[0] ? gl_reg : 32'd0);
                    gs_reg   <= gs_reg >> 1;
                    gl_reg   <= gl_reg << 1;
                end
            end
            ST_ERR: begin
                d2s_reg   <= d2_reg[29:0];
                d2big_reg <= |d2_reg[32:30];
                ggl_reg   <= 62'(gg_reg);
                lhs_reg   <= '0;
                kps_reg   <= kp_reg;
                kds_reg   <= kd_reg;
                errl_reg  <= CW'(errw);
                derrl_reg <= CW'(derr);
                cmd_reg   <= '0;
            end
            ST_MUL: begin
                lhs_reg   <= lhs_sum;
                d2s_reg   <= d2s_reg >> 1;
                ggl_reg   <= ggl_reg << 1;
                cmd_reg   <= cmd_reg + (kps_reg[0] ? errl_reg : '0)
                                     + (kds_reg[0] ? derrl_reg : '0);
                kps_reg   <= kps_reg >> 1;
                kds_reg   <= kds_reg >> 1;
                errl_reg  <= errl_reg <<< 1;
                derrl_reg <= derrl_reg <<< 1;
                if (cnt_reg == MUL_LAST) begin
                    sqv_reg  <= lhs_sum[29:0];
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            end
            ST_SQRT: begin
                sqv_reg <= sqv_reg << 2;
                if (rem_sh >= trial) begin
                    rem_reg  <= 17'(rem_sh - trial);
                    root_reg <= {root_reg[13:0], 1'b1};
                end else begin
                    rem_reg  <= 17'(rem_sh);
                    root_reg <= {root_reg[13:0], 1'b0};
                end
            end
            ST_FIN: begin
                accel_res_reg <= accel_val;
                steer_res_reg <= cmd_sat[CW-1] ? -$signed(steer_mag) : $signed(steer_mag);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && s_fault_active) begin
            m_kind_reg  <= KIND_ACTUATOR;
            m_accel_reg <= '0;
            m_steer_reg <= '0;
            m_ex_reg    <= '0;
            m_ey_reg    <= '0;
            m_eh_reg    <= '0;
            m_last_reg  <= 1'b1;
        end else if (state_reg == ST_ACT && out_free) begin
            m_kind_reg  <= KIND_ACTUATOR;
            m_accel_reg <= accel_res_reg;
            m_steer_reg <= steer_res_reg;
            m_ex_reg    <= '0;
            m_ey_reg    <= '0;
            m_eh_reg    <= '0;
            m_last_reg  <= 1'b0;
        end else if (state_reg == ST_ECHO && out_free) begin
            m_kind_reg  <= KIND_ECHO;
            m_accel_reg <= '0;
            m_steer_reg <= '0;
            m_ex_reg    <= px_reg;
            m_ey_reg    <= py_reg;
            m_eh_reg    <= hd_reg;
            m_last_reg  <= 1'b1;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = m_kind_reg;
    assign m_accel_cmd    = m_accel_reg;
    assign m_steer_cmd    = m_steer_reg;
    assign m_echo_x       = m_ex_reg;
    assign m_echo_y       = m_ey_reg;
    assign m_echo_heading = m_eh_reg;
    assign m_last_item    = m_last_reg;

endmodule

`default_nettype wire

/* src/hpnc_checker.sv */
// Port-level checker of the heading PD navigation controller and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hpnc_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire logic                           s_fault_active,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic                           m_result_kind,
    input wire logic [6:0]                     m_accel_cmd,
    input wire logic signed [8:0]              m_steer_cmd,
    input wire logic                           m_last_item
);
    import hpnc_pkg::*;

    `HPNC_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_accel_cmd) && $stable(m_steer_cmd) && $stable(m_last_item), "result changed while stalled")

    `HPNC_ASSERT(a_fault_zero, s_valid && s_ready && s_fault_active |=> m_valid && m_result_kind == KIND_ACTUATOR && m_accel_cmd == 7'd0 && m_steer_cmd == 9'sd0 && m_last_item, "fault transfer without zero actuator result")

    `HPNC_ASSERT_ALWAYS(a_out_room, s_valid && s_ready |-> !m_valid || m_ready, "input taken while result register blocked")

    `HPNC_ASSERT(a_cmd_range, m_valid && m_result_kind == KIND_ACTUATOR |-> m_accel_cmd <= ACCEL_MAX && m_steer_cmd <= 9'sd180 && m_steer_cmd >= -9'sd180, "actuator command out of range")

endmodule

bind heading_pd_navigation_controller hpnc_checker u_hpnc_checker (.*);

`default_nettype wire
